// ----- rtl/hsl_pkg.sv -----
// Package for the HTTP status line parser: parse phases, character codes and
// the per-byte result structure. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hsl_pkg;

  localparam int unsigned COUNT_BITS_DEF = 16;

  localparam logic [7:0] CHAR_SP   = 8'h20;
  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  localparam logic [16:0] CODE_CONTINUE = 17'd100;
  localparam logic [16:0] CODE_MAX      = 17'h0FFFF;
  localparam logic [16:0] CODE_SAT      = 17'h10000;
  localparam logic [19:0] CODE_RADIX    = 20'd10;

  typedef enum logic [2:0] {
    PH_PROTO  = 3'd0,
    PH_SEEK   = 3'd1,
    PH_CODE   = 3'd2,
    PH_TEXT   = 3'd3,
    PH_END    = 3'd4,
    PH_CHK_CR = 3'd5,
    PH_CHK_LF = 3'd6,
    PH_DONE   = 3'd7
  } phase_t;

  typedef struct packed {
    logic        fire;
    logic [15:0] consumed;
    logic [15:0] status_code;
    logic        parse_error;
  } result_t;

endpackage : hsl_pkg

`default_nettype wire

// ----- rtl/hsl_if.sv -----
// Valid/ready channel interfaces for the status line parser: the byte stream
// in and the parse result out. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface hsl_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface : hsl_byte_if

interface hsl_result_if;
  logic        valid;
  logic        ready;
  logic [15:0] consumed;
  logic [15:0] status_code;
  logic        parse_error;

  modport source (output valid, output consumed, output status_code, output parse_error,
                  input ready);
  modport sink (input valid, input consumed, input status_code, input parse_error,
                output ready);
endinterface : hsl_result_if

`default_nettype wire

// ----- rtl/hsl_step.sv -----
// Combinational next-state and result logic for one byte of the status line.
// Depends on hsl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hsl_step #(
  parameter int unsigned COUNT_BITS = hsl_pkg::COUNT_BITS_DEF
) (
  input  hsl_pkg::phase_t         phase,
  input  logic [COUNT_BITS-1:0]   count,
  input  logic [16:0]             code,
  input  logic                    first_cr,
  input  logic [7:0]              data_byte,
  input  logic                    last_byte,
  output hsl_pkg::phase_t         phase_next,
  output logic [COUNT_BITS-1:0]   count_next,
  output logic [16:0]             code_next,
  output logic                    first_cr_next,
  output hsl_pkg::result_t        res
);
  import hsl_pkg::*;

  localparam int unsigned UW = COUNT_BITS + 2;
  localparam logic [UW-1:0] COUNT_MAX_W = UW'({COUNT_BITS{1'b1}});

  logic                  is_digit;
  logic                  is_end;
  logic [COUNT_BITS-1:0] count_inc;
  logic [19:0]           code_mac;
  logic [16:0]           code_acc;
  logic                  give;
  logic                  give_err;
  logic [UW-1:0]         give_used;
  logic [16:0]           give_code;
  logic                  line_end;
  logic [UW-1:0]         used_sat;
  logic [33:0]           used_wide;

  assign is_digit  = (data_byte >= CHAR_ZERO) && (data_byte <= CHAR_NINE);
  assign is_end    = (data_byte == CHAR_CR) || (data_byte == CHAR_LF);
  assign count_inc = (count == {COUNT_BITS{1'b1}}) ? count : count + 1'b1;
  assign code_mac  = 20'(code) * CODE_RADIX + 20'(data_byte[3:0]);
  assign code_acc  = (code_mac > 20'(CODE_SAT)) ? CODE_SAT : code_mac[16:0];

  always_comb begin
    phase_next    = phase;
    count_next    = count;
    code_next     = code;
    first_cr_next = first_cr;
    give          = 1'b0;
    give_err      = 1'b0;
    give_used     = UW'(count);
    give_code     = code;
    line_end      = 1'b0;

    case (phase)
      PH_DONE: begin
      end
      PH_END: begin
        if (data_byte == CHAR_LF) begin
          count_next = count_inc;
          give_used  = UW'(count_inc);
          if (code == CODE_CONTINUE && !last_byte) begin
            phase_next = PH_CHK_CR;
          end else begin
            give = 1'b1;
          end
        end else if (code == CODE_CONTINUE && data_byte == CHAR_CR && !last_byte) begin
          phase_next = PH_CHK_LF;
        end else begin
          give = 1'b1;
        end
      end
      PH_CHK_CR: begin
        if (data_byte == CHAR_CR && !last_byte) begin
          phase_next = PH_CHK_LF;
        end else begin
          give = 1'b1;
        end
      end
      PH_CHK_LF: begin
        give = 1'b1;
        if (data_byte == CHAR_LF) begin
          give_used = UW'(count) + UW'(2);
        end
      end
      default: begin
        // Line phases: the byte counter equals the bytes seen so far.
        if (count == '0 && last_byte) begin
          give     = 1'b1;
          give_err = 1'b1;
        end else if (count == COUNT_BITS'(1) && first_cr && data_byte == CHAR_LF) begin
          // A leading blank line consumes its two bytes and carries no code.
          give      = 1'b1;
          give_used = UW'(2);
          give_code = '0;
        end else begin
          if (count == '0) begin
            first_cr_next = (data_byte == CHAR_CR);
          end
          count_next = count_inc;
          give_used  = UW'(count_inc);
          case (phase)
            PH_PROTO: begin
              if (data_byte == CHAR_SP) begin
                phase_next = PH_SEEK;
              end
            end
            PH_SEEK: begin
              if (data_byte != CHAR_SP) begin
                if (!is_digit) begin
                  give     = 1'b1;
                  give_err = 1'b1;
                end else begin
                  code_next  = 17'(data_byte[3:0]);
                  phase_next = PH_CODE;
                end
              end
            end
            PH_CODE: begin
              if (is_digit) begin
                code_next = code_acc;
              end else if (code > CODE_MAX) begin
                give     = 1'b1;
                give_err = 1'b1;
              end else if (is_end) begin
                line_end = 1'b1;
              end else begin
                phase_next = PH_TEXT;
              end
            end
            default: begin
              phase_next = PH_TEXT;
              if (is_end) begin
                line_end = 1'b1;
              end
            end
          endcase
          if (line_end) begin
            if (last_byte) begin
              give = 1'b1;
            end else begin
              phase_next = PH_END;
            end
          end else if (!give && last_byte) begin
            // The buffer ended before the line did.
            give     = 1'b1;
            give_err = 1'b1;
          end
        end
      end
    endcase

    if (give && !last_byte) begin
      phase_next = PH_DONE;
    end
    if (last_byte && (give || phase == PH_DONE)) begin
      phase_next    = PH_PROTO;
      count_next    = '0;
      code_next     = '0;
      first_cr_next = 1'b0;
    end
  end

  assign used_sat  = (give_used > COUNT_MAX_W) ? COUNT_MAX_W : give_used;
  assign used_wide = 34'(used_sat);

  always_comb begin
    res.fire        = give;
    res.parse_error = give_err;
    res.consumed    = '0;
    res.status_code = '0;
    if (!give_err) begin
      res.consumed    = (used_wide > 34'h0FFFF) ? 16'hFFFF : used_wide[15:0];
      res.status_code = give_code[15:0];
    end
  end

endmodule : hsl_step

`default_nettype wire

// ----- rtl/http_status_line_parser.sv -----
// A byte is held in the input register once accepted; its result is loaded into
// the result register when the held byte is taken. Throughput: one byte per cycle
// while the result channel is not stalled. Reset: synchronous, active high; clears
// both registers' valid flags and returns the parser to the protocol token phase.
// Depends on hsl_pkg, hsl_if and hsl_step.
`timescale 1ns / 1ps
`default_nettype none

module http_status_line_parser #(
  parameter int unsigned COUNT_BITS = hsl_pkg::COUNT_BITS_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst,
  hsl_byte_if.sink     stream,
  hsl_result_if.source result
);
  import hsl_pkg::*;

  logic                  in_valid;
  logic [7:0]            in_byte;
  logic                  in_last;
  logic                  advance;
  logic                  take;

  phase_t                phase;
  phase_t                phase_next;
  logic [COUNT_BITS-1:0] count;
  logic [COUNT_BITS-1:0] count_next;
  logic [16:0]           code;
  logic [16:0]           code_next;
  logic                  first_cr;
  logic                  first_cr_next;
  result_t               res;

  logic                  out_valid;
  logic [15:0]           out_consumed;
  logic [15:0]           out_code;
  logic                  out_error;

  // The held byte moves on whenever the result register is free or draining.
  assign advance      = !out_valid || result.ready;
  assign take         = in_valid && advance;
  assign stream.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (stream.ready) begin
      in_valid <= stream.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stream.valid && stream.ready) begin
      in_byte <= stream.data_byte;
      in_last <= stream.last_byte;
    end
  end

  hsl_step #(
    .COUNT_BITS(COUNT_BITS)
  ) u_step (
    .phase        (phase),
    .count        (count),
    .code         (code),
    .first_cr     (first_cr),
    .data_byte    (in_byte),
    .last_byte    (in_last),
    .phase_next   (phase_next),
    .count_next   (count_next),
    .code_next    (code_next),
    .first_cr_next(first_cr_next),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_PROTO;
      count    <= '0;
      code     <= '0;
      first_cr <= 1'b0;
    end else if (take) begin
      phase    <= phase_next;
      count    <= count_next;
      code     <= code_next;
      first_cr <= first_cr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= take && res.fire;
    end
  end

  always_ff @(posedge clk) begin
    if (take && res.fire) begin
      out_consumed <= res.consumed;
      out_code     <= res.status_code;
      out_error    <= res.parse_error;
    end
  end

  assign result.valid       = out_valid;
  assign result.consumed    = out_consumed;
  assign result.status_code = out_code;
  assign result.parse_error = out_error;

endmodule : http_status_line_parser

`default_nettype wire

// ----- test/http_status_line_parser_test.sv -----
// Self-checking testbench for http_status_line_parser: directed and random
// response buffers with random idling on both channels, results predicted in
// the bench. Depends on hsl_pkg, hsl_if and the parser RTL.
`timescale 1ns / 1ps

module http_status_line_parser_test;
  import hsl_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int RANDOM_BYTES = 1150;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic [15:0] consumed;
    logic [15:0] code;
    logic        err;
  } status_line_t;

  typedef struct packed {
    logic [7:0]   b;
    logic         lst;
    logic         typed;
    status_line_t want;
  } dir_row_t;

  logic clk;
  logic rst;

  hsl_byte_if   stream_ch();
  hsl_result_if result_ch();

  http_status_line_parser i_dut (
    .clk(clk),
    .rst(rst),
    .stream(stream_ch),
    .result(result_ch)
  );

  // Parser state as the bench sees it.
  phase_t      parse_ph;
  logic [15:0] seen_cnt;
  logic [16:0] code_acc;
  logic        digit_flag;
  logic        lead_cr;

  status_line_t status_q[$];
  dir_row_t     directed_rows[$];
  logic [7:0]   frame_q[$];

  logic calm = 1'b0;
  int   stall_left = 0;
  int   cycle_count = 0;
  int   fail_count = 0;
  int   bytes_sent = 0;
  int   frames_sent = 0;
  int   results_checked = 0;
  int   error_results = 0;

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void clear_parse();
    parse_ph   = PH_PROTO;
    seen_cnt   = '0;
    code_acc   = '0;
    digit_flag = 1'b0;
    lead_cr    = 1'b0;
  endfunction

  function automatic void bump_count();
    if (seen_cnt != 16'hFFFF) seen_cnt = seen_cnt + 16'd1;
  endfunction

  // Builds the result and moves to the ignore phase, or starts over on the
  // final byte of the buffer.
  function automatic status_line_t emit(input logic lst, input logic err,
                                        input logic [17:0] used);
    status_line_t r;
    r.consumed = (used > 18'h0FFFF) ? 16'hFFFF : used[15:0];
    r.code     = code_acc[15:0];
    r.err      = err;
    if (err) begin
      r.consumed = '0;
      r.code     = '0;
    end
    if (lst) clear_parse();
    else parse_ph = PH_DONE;
    return r;
  endfunction

  task automatic parse_byte(input logic [7:0] b, input logic lst,
                            output logic fires, output status_line_t r);
    logic        is_end;
    logic        is_dig;
    logic        line_byte;
    logic        hit_end;
    logic [19:0] wide;
    fires     = 1'b0;
    r         = '0;
    line_byte = 1'b0;
    hit_end   = 1'b0;
    is_end    = (b == CHAR_CR) || (b == CHAR_LF);
    is_dig    = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
    case (parse_ph)
      PH_DONE: begin
        if (lst) clear_parse();
      end
      PH_END: begin
        if (b == CHAR_LF) begin
          bump_count();
          if (code_acc == CODE_CONTINUE && !lst) begin
            parse_ph = PH_CHK_CR;
          end else begin
            fires = 1'b1;
            r = emit(lst, 1'b0, {2'b0, seen_cnt});
          end
        end else if (code_acc == CODE_CONTINUE && b == CHAR_CR && !lst) begin
          parse_ph = PH_CHK_LF;
        end else begin
          fires = 1'b1;
          r = emit(lst, 1'b0, {2'b0, seen_cnt});
        end
      end
      PH_CHK_CR: begin
        if (b == CHAR_CR && !lst) begin
          parse_ph = PH_CHK_LF;
        end else begin
          fires = 1'b1;
          r = emit(lst, 1'b0, {2'b0, seen_cnt});
        end
      end
      PH_CHK_LF: begin
        fires = 1'b1;
        r = emit(lst, 1'b0, (b == CHAR_LF) ? {2'b0, seen_cnt} + 18'd2 : {2'b0, seen_cnt});
      end
      default: line_byte = 1'b1;
    endcase

    if (line_byte) begin
      if (seen_cnt == 16'd0 && lst) begin
        fires = 1'b1;
        r = emit(1'b1, 1'b1, '0);
      end else if (seen_cnt == 16'd1 && lead_cr && b == CHAR_LF) begin
        // Blank line ahead of the status line; the code is still zero here.
        fires = 1'b1;
        r = emit(lst, 1'b0, 18'd2);
      end else begin
        if (seen_cnt == 16'd0) lead_cr = (b == CHAR_CR);
        bump_count();
        case (parse_ph)
          PH_PROTO: begin
            if (b == CHAR_SP) parse_ph = PH_SEEK;
          end
          PH_SEEK: begin
            if (b != CHAR_SP) begin
              if (!is_dig) begin
                fires = 1'b1;
                r = emit(lst, 1'b1, '0);
              end else begin
                digit_flag = 1'b1;
                code_acc   = 17'(b - CHAR_ZERO);
                parse_ph   = PH_CODE;
              end
            end
          end
          PH_CODE: begin
            if (is_dig) begin
              wide = {3'b0, code_acc} * CODE_RADIX + 20'(b - CHAR_ZERO);
              code_acc = (wide > CODE_SAT) ? CODE_SAT : wide[16:0];
            end else if (!digit_flag || code_acc > CODE_MAX) begin
              fires = 1'b1;
              r = emit(lst, 1'b1, '0);
            end else if (is_end) begin
              hit_end = 1'b1;
            end else begin
              parse_ph = PH_TEXT;
            end
          end
          default: begin
            parse_ph = PH_TEXT;
            hit_end  = is_end;
          end
        endcase
        if (hit_end) begin
          if (lst) begin
            fires = 1'b1;
            r = emit(1'b1, 1'b0, {2'b0, seen_cnt});
          end else begin
            parse_ph = PH_END;
          end
        end else if (!fires && lst) begin
          // The buffer ended before the status line did.
          fires = 1'b1;
          r = emit(1'b1, 1'b1, '0);
        end
      end
    end
  endtask

  // Mostly short gaps, a few long ones, none during a calm stretch.
  function automatic int idle_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic lst, input logic typed,
                           input status_line_t want);
    int           gap;
    logic         fires;
    status_line_t got;
    gap = idle_len();
    if (gap != 0) begin
      stream_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    stream_ch.valid     <= 1'b1;
    stream_ch.data_byte <= b;
    stream_ch.last_byte <= lst;
    @(posedge clk);
    while (!stream_ch.ready) @(posedge clk);
    parse_byte(b, lst, fires, got);
    if (typed) status_q.push_back(want);
    else if (fires) status_q.push_back(got);
    bytes_sent++;
  endtask

  // Holds the stream off until every pending result has been returned.
  task automatic drain_results();
    stream_ch.valid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic add_row(input logic [7:0] b, input logic lst, input logic typed,
                         input logic [15:0] consumed, input logic [15:0] code,
                         input logic err);
    dir_row_t row;
    row.b     = b;
    row.lst   = lst;
    row.typed = typed;
    row.want  = '{consumed: consumed, code: code, err: err};
    directed_rows.push_back(row);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
      stall_left      <= 0;
    end else if (stall_left != 0) begin
      result_ch.ready <= 1'b0;
      stall_left      <= stall_left - 1;
    end else begin
      result_ch.ready <= 1'b1;
      stall_left      <= idle_len();
    end
  end

  always @(posedge clk) begin : result_check
    status_line_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (status_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("%0t: result with none pending: consumed %0d code %0d error %0b",
                   $time, result_ch.consumed, result_ch.status_code,
                   result_ch.parse_error);
      end else begin
        want = status_q.pop_front();
        results_checked++;
        if (want.err) error_results++;
        if (result_ch.consumed !== want.consumed || result_ch.status_code !== want.code ||
            result_ch.parse_error !== want.err) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: mismatch: expected consumed %0d code %0d error %0b, got %0d %0d %0b",
                     $time, want.consumed, want.code, want.err, result_ch.consumed,
                     result_ch.status_code, result_ch.parse_error);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results pending", cycle_count,
               status_q.size());
      $display("http_status_line_parser_test: FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    int          kind;
    int          n;
    int          cut;
    int unsigned code_pick;
    int unsigned pw;
    logic [7:0]  v;
    logic [7:0]  digit;
    rst                 <= 1'b1;
    stream_ch.valid     <= 1'b0;
    stream_ch.data_byte <= '0;
    stream_ch.last_byte <= 1'b0;
    clear_parse();

    // One-byte buffer, with the top byte value.
    add_row(8'hFF, 1'b1, 1'b1, 16'd0, 16'd0, 1'b1);
    // Blank line: CR LF up front.
    add_row(CHAR_CR, 1'b0, 1'b0, 16'd0, 16'd0, 1'b0);
    add_row(CHAR_LF, 1'b1, 1'b1, 16'd2, 16'd0, 1'b0);
    // A sign where the code should start.
    add_row(CHAR_SP, 1'b0, 1'b0, 16'd0, 16'd0, 1'b0);
    add_row("+", 1'b1, 1'b1, 16'd0, 16'd0, 1'b1);
    // Code beyond 16 bits.
    add_row(CHAR_SP, 1'b0, 1'b0, 16'd0, 16'd0, 1'b0);
    repeat (5) add_row("9", 1'b0, 1'b0, 16'd0, 16'd0, 1'b0);
    add_row(";", 1'b1, 1'b1, 16'd0, 16'd0, 1'b1);
    // Buffer ends in the middle of the code.
    add_row(CHAR_SP, 1'b0, 1'b0, 16'd0, 16'd0, 1'b0);
    add_row("1", 1'b1, 1'b1, 16'd0, 16'd0, 1'b1);
    // Continue code with its blank line absorbed, then a zero byte ignored.
    add_row(CHAR_SP, 1'b0, 1'b0, 16'd0, 16'd0, 1'b0);
    add_row("1", 1'b0, 1'b0, 16'd0, 16'd0, 1'b0);
    add_row("0", 1'b0, 1'b0, 16'd0, 16'd0, 1'b0);
    add_row("0", 1'b0, 1'b0, 16'd0, 16'd0, 1'b0);
    add_row(CHAR_CR, 1'b0, 1'b0, 16'd0, 16'd0, 1'b0);
    add_row(CHAR_LF, 1'b0, 1'b0, 16'd0, 16'd0, 1'b0);
    add_row(CHAR_CR, 1'b0, 1'b0, 16'd0, 16'd0, 1'b0);
    add_row(CHAR_LF, 1'b0, 1'b1, 16'd8, 16'd100, 1'b0);
    add_row(8'h00, 1'b1, 1'b0, 16'd0, 16'd0, 1'b0);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_byte(directed_rows[i].b, directed_rows[i].lst, directed_rows[i].typed,
                directed_rows[i].want);
    frames_sent += 6;
    drain_results();

    while (bytes_sent < RANDOM_BYTES + directed_rows.size()) begin
      frame_q.delete();
      calm = ($urandom_range(0, 9) < 2);
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
        n = $urandom_range(1, 12);
        repeat (n) frame_q.push_back(8'($urandom_range(0, 255)));
      end else if (kind < 12) begin
        frame_q.push_back(CHAR_CR);
        frame_q.push_back(CHAR_LF);
        n = $urandom_range(0, 4);
        repeat (n) frame_q.push_back(8'($urandom_range(0, 255)));
      end else begin
        n = $urandom_range(0, 6);
        repeat (n) begin
          v = 8'($urandom_range(0, 255));
          while (v == CHAR_SP) v = 8'($urandom_range(0, 255));
          frame_q.push_back(v);
        end
        n = $urandom_range(1, 3);
        repeat (n) frame_q.push_back(CHAR_SP);
        if ($urandom_range(0, 19) == 0) frame_q.push_back($urandom_range(0, 1) ? "+" : "-");
        case ($urandom_range(0, 11))
          0, 1, 2: code_pick = 100;
          3:       code_pick = 200;
          4:       code_pick = 404;
          5:       code_pick = 0;
          6:       code_pick = 65535;
          7:       code_pick = 65536;
          8:       code_pick = $urandom_range(65536, 999999);
          9:       code_pick = $urandom_range(0, 120000);
          default: code_pick = $urandom_range(0, 999);
        endcase
        if ($urandom_range(0, 9) == 0) frame_q.push_back(CHAR_ZERO);
        pw = 1;
        while (pw <= code_pick / 10) pw = pw * 10;
        while (pw != 0) begin
          digit = 8'((code_pick / pw) % 10);
          frame_q.push_back(CHAR_ZERO + digit);
          pw = pw / 10;
        end
        if ($urandom_range(0, 1)) begin
          n = $urandom_range(1, 6);
          frame_q.push_back(CHAR_SP);
          repeat (n) begin
            v = 8'($urandom_range(0, 255));
            while (v == CHAR_CR || v == CHAR_LF) v = 8'($urandom_range(0, 255));
            frame_q.push_back(v);
          end
        end
        frame_q.push_back($urandom_range(0, 3) != 0 ? CHAR_CR : CHAR_LF);
        if ($urandom_range(0, 3) != 0) frame_q.push_back(CHAR_LF);
        if (code_pick == 100 && $urandom_range(0, 3) != 0) begin
          frame_q.push_back(CHAR_CR);
          if ($urandom_range(0, 3) != 0) frame_q.push_back(CHAR_LF);
        end
        n = $urandom_range(0, 3);
        repeat (n) frame_q.push_back(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 9) == 0 && frame_q.size() > 1) begin
          cut = $urandom_range(1, frame_q.size() - 1);
          while (frame_q.size() > cut) void'(frame_q.pop_back());
        end
      end
      foreach (frame_q[i])
        send_byte(frame_q[i], i == frame_q.size() - 1, 1'b0, '0);
      frames_sent++;
      if (frames_sent % 50 == 0) drain_results();
    end

    calm = 1'b0;
    stream_ch.valid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d buffers (%0d bytes); checked %0d results, %0d of them parse errors.",
             frames_sent, bytes_sent, results_checked, error_results);
    $display("Mismatches and unexpected results: %0d", fail_count);
    if (fail_count == 0) begin
      $display("http_status_line_parser_test: PASS");
    end else begin
      $display("http_status_line_parser_test: FAIL");
    end
    $finish;
  end

endmodule : http_status_line_parser_test
